// ===== rtl/wfs_pkg.sv =====
`default_nettype none
package wfs_pkg;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 20;
	localparam int STAGE_W = 5;
	localparam int XY_W = 40;
	localparam int Z_W = 25;
	localparam int ATAN_W = 22;
	localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		22'd1474560, 22'd870484, 22'd459940, 22'd233473, 22'd117189,
		22'd58652, 22'd29333, 22'd14667, 22'd7334, 22'd3667,
		22'd1833, 22'd917, 22'd458, 22'd229, 22'd115,
		22'd57, 22'd29, 22'd14, 22'd7, 22'd4
	};
	localparam logic signed [Z_W-1:0] QUARTER_TURN = 25'sd2949120;

	// squared distance and the restoring divider for 2^64 / r2
	localparam int R2_W = 33;
	localparam int DIV_STEPS = 64;
	localparam int DREM_W = 34;
	localparam int DIVQ_W = 64;

	// digit-by-digit square root, operand left aligned
	localparam int SQV_W = 64;
	localparam int SQR_W = 32;
	localparam int SQREM_W = 36;
	localparam int SQ1_STEPS = 32;
	localparam int SQ2_STEPS = 16;
	localparam int DSQ_STEPS = 19;

	// stages from accept to the last stage before the output registers
	localparam int PIPE_DEPTH = 3 + DIV_STEPS + SQ1_STEPS + SQ2_STEPS;

	localparam logic [15:0] GAIN_MAX = 16'hFFFF;
	localparam logic [18:0] DELAY_MAX = 19'h7FFFF;
	localparam logic [15:0] SPM_RESET = 16'd32914;
	localparam logic signed [19:0] HALF_SPAN = 20'sd11520;

	typedef enum logic [1:0] {
		CFG_SOURCE_X = 2'd0,
		CFG_SOURCE_Y = 2'd1,
		CFG_SPM      = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [R2_W-1:0]   den;
		logic [DIVQ_W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [SQV_W-1:0]   val;
		logic [SQREM_W-1:0] rem;
		logic [SQR_W-1:0]   root;
	} sqrt_t;

endpackage
`default_nettype wire

// ===== rtl/wfs_cordic_cell.sv =====
`default_nettype none
module wfs_cordic_cell (
	input  logic                         clk,
	input  logic [wfs_pkg::STAGE_W-1:0]  stage,
	input  wfs_pkg::cordic_t             vec_i,
	output wfs_pkg::cordic_t             vec_o
);
	import wfs_pkg::*;

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  ang;
	logic                   y_pos;

	always_comb begin
		xs    = vec_i.x >>> stage;
		ys    = vec_i.y >>> stage;
		ang   = signed'(Z_W'(ATAN_TAB[stage]));
		y_pos = !vec_i.y[XY_W-1] && (vec_i.y != '0);
	end

	// rotate toward the x axis by one table angle
	always_ff @(posedge clk) begin
		if (y_pos) begin
			vec_o.x <= vec_i.x + ys;
			vec_o.y <= vec_i.y - xs;
			vec_o.z <= vec_i.z + ang;
		end else begin
			vec_o.x <= vec_i.x - ys;
			vec_o.y <= vec_i.y + xs;
			vec_o.z <= vec_i.z - ang;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wfs_div_cell.sv =====
`default_nettype none
module wfs_div_cell (
	input  logic          clk,
	input  wfs_pkg::div_t div_i,
	output wfs_pkg::div_t div_o
);
	import wfs_pkg::*;

	logic [DREM_W-1:0] sh;
	logic [DREM_W-1:0] den;
	logic              ge;

	always_comb begin
		sh  = {div_i.rem[DREM_W-2:0], 1'b0};
		den = DREM_W'(div_i.den);
		ge  = sh >= den;
	end

	// one quotient bit: subtract when the divisor fits
	always_ff @(posedge clk) begin
		div_o.rem <= ge ? sh - den : sh;
		div_o.den <= div_i.den;
		div_o.quo <= {div_i.quo[DIVQ_W-2:0], ge};
	end

endmodule
`default_nettype wire

// ===== rtl/wfs_sqrt_cell.sv =====
`default_nettype none
module wfs_sqrt_cell (
	input  logic           clk,
	input  wfs_pkg::sqrt_t sq_i,
	output wfs_pkg::sqrt_t sq_o
);
	import wfs_pkg::*;

	logic [SQREM_W-1:0] r4;
	logic [SQREM_W-1:0] trial;
	logic               ge;

	always_comb begin
		r4    = {sq_i.rem[SQREM_W-3:0], sq_i.val[SQV_W-1 -: 2]};
		trial = SQREM_W'({sq_i.root, 2'b01});
		ge    = r4 >= trial;
	end

	// one root bit per cell, consume the top two operand bits
	always_ff @(posedge clk) begin
		sq_o.val  <= {sq_i.val[SQV_W-3:0], 2'b00};
		sq_o.rem  <= ge ? r4 - trial : r4;
		sq_o.root <= {sq_i.root[SQR_W-2:0], ge};
	end

endmodule
`default_nettype wire

// ===== rtl/wfs_speaker_gain_delay_unit.sv =====
`default_nettype none
// Wave field synthesis driving values, one loudspeaker per item. Raise start
// with the speaker fields; busy stays low, so a new speaker is taken in every
// cycle. The result for each speaker appears at the output registers for one
// cycle, marked by done; results leave in input order and the receiver cannot
// stall them. The latency is set by the longest chain of
// cells: a 64-cell restoring divider forming 2^64 / r2 followed by a 32-cell
// and a 16-cell square root chain for the gain. The bearing runs through 20
// CORDIC cells and the delay through a 19-cell square root chain; both are
// held in shift lines until the gain is ready. Configuration registers
// (source_x, source_y, samples_per_meter) are always ready and must only be
// written while no speaker is in flight.
module wfs_speaker_gain_delay_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [6:0]  speaker_index,
	input  logic [15:0] speaker_x,
	input  logic [15:0] speaker_y,
	input  logic [16:0] speaker_facing,
	output logic        done,
	output logic [6:0]  result_index,
	output logic        active,
	output logic [15:0] gain,
	output logic [18:0] delay,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import wfs_pkg::*;

	localparam int CORDIC_END = 2 + CORDIC_STEPS;
	localparam int ACT_STAGE = CORDIC_END + 1;
	localparam int DSQ_END = 5 + DSQ_STEPS;
	localparam int DLY_STAGE = DSQ_END + 1;

	// configuration
	logic [15:0] srcx_q;
	logic [15:0] srcy_q;
	logic [15:0] spm_q;
	logic [31:0] spm2_q;

	// front end
	logic signed [16:0] dx_s1;
	logic signed [16:0] dy_s1;
	logic signed [33:0] dxx_full;
	logic signed [33:0] dyy_full;
	logic [31:0]        dxx_s2;
	logic [31:0]        dyy_s2;
	logic [R2_W-1:0]    r2_n;
	logic [R2_W-1:0]    r2_s3;
	logic [XY_W-1:0]    xe;
	logic [XY_W-1:0]    ye;
	cordic_t            cinit;
	cordic_t            cinit_s2;

	// delay front end
	logic [48:0]  phi_s4;
	logic [47:0]  plo_s4;
	logic [65:0]  nsum;
	logic [41:0]  m_s5;

	// bearing
	logic signed [Z_W-1:0] zr;
	logic signed [19:0]    bear;
	logic signed [19:0]    fac_ext;
	logic                  act_n;

	// shift lines
	logic        vld_q [1:PIPE_DEPTH];
	logic [6:0]  idx_q [1:PIPE_DEPTH];
	logic [16:0] fac_q [1:CORDIC_END];
	logic        zro_q [2:CORDIC_END];
	logic        one_q [3:PIPE_DEPTH];
	logic        zs_q  [5:DSQ_END];
	logic        st_q  [5:DSQ_END];
	logic        act_q [ACT_STAGE:PIPE_DEPTH];
	logic [18:0] dly_q [DLY_STAGE:PIPE_DEPTH];

	// cell chains
	cordic_t cv  [0:CORDIC_STEPS];
	div_t    dv  [0:DIV_STEPS];
	sqrt_t   g1v [0:SQ1_STEPS];
	sqrt_t   g2v [0:SQ2_STEPS];
	sqrt_t   dsv [0:DSQ_STEPS];

	// outputs
	logic        done_q;
	logic [6:0]  rindex_q;
	logic        active_q;
	logic [15:0] gain_q;
	logic [18:0] delay_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srcx_q <= '0;
			srcy_q <= '0;
			spm_q  <= SPM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SOURCE_X: srcx_q <= cfg_data;
				CFG_SOURCE_Y: srcy_q <= cfg_data;
				CFG_SPM:      spm_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// spm squared only follows configuration, so registering it is harmless
	always_ff @(posedge clk) begin
		spm2_q <= 32'(spm_q) * 32'(spm_q);
	end

	// stage 1: offset from the source, exact in 17 bits
	always_ff @(posedge clk) begin
		dx_s1 <= signed'({speaker_x[15], speaker_x}) - signed'({srcx_q[15], srcx_q});
		dy_s1 <= signed'({speaker_y[15], speaker_y}) - signed'({srcy_q[15], srcy_q});
	end

	// stage 2: squares, and the CORDIC start vector folded into the right half
	always_comb begin
		dxx_full = dx_s1 * dx_s1;
		dyy_full = dy_s1 * dy_s1;
		xe = {{(XY_W - 37){dx_s1[16]}}, dx_s1, 20'b0};
		ye = {{(XY_W - 37){dy_s1[16]}}, dy_s1, 20'b0};
		if (!dx_s1[16]) begin
			cinit.x = xe;
			cinit.y = ye;
			cinit.z = '0;
		end else if (!dy_s1[16]) begin
			cinit.x = ye;
			cinit.y = -xe;
			cinit.z = QUARTER_TURN;
		end else begin
			cinit.x = -ye;
			cinit.y = xe;
			cinit.z = -QUARTER_TURN;
		end
	end

	always_ff @(posedge clk) begin
		dxx_s2   <= dxx_full[31:0];
		dyy_s2   <= dyy_full[31:0];
		cinit_s2 <= cinit;
	end

	// stage 3: squared distance
	assign r2_n = R2_W'(dxx_s2) + R2_W'(dyy_s2);

	always_ff @(posedge clk) begin
		r2_s3 <= r2_n;
	end

	// stages 4 and 5: N = r2 * spm^2 + spm - 1, keep N / 2^24 for the root
	assign nsum = 66'({phi_s4, 16'b0}) + 66'(plo_s4) + 66'(spm_q) - 66'd1;

	always_ff @(posedge clk) begin
		phi_s4 <= 49'(r2_s3[32:16]) * 49'(spm2_q);
		plo_s4 <= 48'(r2_s3[15:0]) * 48'(spm2_q);
		m_s5   <= nsum[65:24];
	end

	// CORDIC chain
	assign cv[0] = cinit_s2;
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		wfs_cordic_cell u_cell (
			.clk   (clk),
			.stage (STAGE_W'(i)),
			.vec_i (cv[i]),
			.vec_o (cv[i+1])
		);
	end

	// divider chain for floor(2^64 / r2); the leading numerator bit seeds rem
	assign dv[0] = '{rem: DREM_W'(1), den: r2_s3, quo: '0};
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		wfs_div_cell u_cell (
			.clk   (clk),
			.div_i (dv[i]),
			.div_o (dv[i+1])
		);
	end

	// square root of the quotient, then square root again: fourth root
	assign g1v[0] = '{val: dv[DIV_STEPS].quo, rem: '0, root: '0};
	for (genvar i = 0; i < SQ1_STEPS; i++) begin : g_sq1
		wfs_sqrt_cell u_cell (
			.clk  (clk),
			.sq_i (g1v[i]),
			.sq_o (g1v[i+1])
		);
	end

	assign g2v[0] = '{val: {g1v[SQ1_STEPS].root, 32'b0}, rem: '0, root: '0};
	for (genvar i = 0; i < SQ2_STEPS; i++) begin : g_sq2
		wfs_sqrt_cell u_cell (
			.clk  (clk),
			.sq_i (g2v[i]),
			.sq_o (g2v[i+1])
		);
	end

	// delay root over the low 38 bits; higher bits mean saturation
	assign dsv[0] = '{val: {m_s5[37:0], 26'b0}, rem: '0, root: '0};
	for (genvar i = 0; i < DSQ_STEPS; i++) begin : g_dsq
		wfs_sqrt_cell u_cell (
			.clk  (clk),
			.sq_i (dsv[i]),
			.sq_o (dsv[i+1])
		);
	end

	// bearing rounded to 1/128 degree, compared without wrap
	always_comb begin
		zr      = cv[CORDIC_STEPS].z + 25'sd128;
		bear    = zro_q[CORDIC_END] ? 20'sd0 : {{3{zr[Z_W-1]}}, zr[Z_W-1:8]};
		fac_ext = {{3{fac_q[CORDIC_END][16]}}, fac_q[CORDIC_END]};
		act_n   = (bear <= fac_ext + HALF_SPAN) && (bear >= fac_ext - HALF_SPAN);
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[1] <= 1'b0;
		end else begin
			vld_q[1] <= start && !busy;
		end
	end

	for (genvar k = 2; k <= PIPE_DEPTH; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// heads of the side lines
	always_ff @(posedge clk) begin
		idx_q[1]         <= speaker_index;
		fac_q[1]         <= speaker_facing;
		zro_q[2]         <= (dx_s1 == '0) && (dy_s1 == '0);
		one_q[3]         <= r2_n <= R2_W'(1);
		zs_q[5]          <= spm_q == '0;
		st_q[5]          <= nsum[65:62] != '0;
		act_q[ACT_STAGE] <= act_n;
		dly_q[DLY_STAGE] <= zs_q[DSQ_END] ? '0 :
			(st_q[DSQ_END] ? DELAY_MAX : dsv[DSQ_STEPS].root[18:0]);
	end

	// advance the side lines
	for (genvar k = 2; k <= PIPE_DEPTH; k++) begin : g_idx
		always_ff @(posedge clk) begin
			idx_q[k] <= idx_q[k-1];
		end
	end

	for (genvar k = 2; k <= CORDIC_END; k++) begin : g_fac
		always_ff @(posedge clk) begin
			fac_q[k] <= fac_q[k-1];
		end
	end

	for (genvar k = 3; k <= CORDIC_END; k++) begin : g_zro
		always_ff @(posedge clk) begin
			zro_q[k] <= zro_q[k-1];
		end
	end

	for (genvar k = 4; k <= PIPE_DEPTH; k++) begin : g_one
		always_ff @(posedge clk) begin
			one_q[k] <= one_q[k-1];
		end
	end

	for (genvar k = 6; k <= DSQ_END; k++) begin : g_dflag
		always_ff @(posedge clk) begin
			zs_q[k] <= zs_q[k-1];
			st_q[k] <= st_q[k-1];
		end
	end

	for (genvar k = ACT_STAGE + 1; k <= PIPE_DEPTH; k++) begin : g_act
		always_ff @(posedge clk) begin
			act_q[k] <= act_q[k-1];
		end
	end

	for (genvar k = DLY_STAGE + 1; k <= PIPE_DEPTH; k++) begin : g_dly
		always_ff @(posedge clk) begin
			dly_q[k] <= dly_q[k-1];
		end
	end

	// output registers: hold each result for exactly one cycle under done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[PIPE_DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		rindex_q <= idx_q[PIPE_DEPTH];
		active_q <= act_q[PIPE_DEPTH];
		gain_q   <= one_q[PIPE_DEPTH] ? GAIN_MAX : g2v[SQ2_STEPS].root[15:0];
		delay_q  <= dly_q[PIPE_DEPTH];
	end

	assign done         = done_q;
	assign result_index = rindex_q;
	assign active       = active_q;
	assign gain         = gain_q;
	assign delay        = delay_q;

	// every accepted speaker comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(PIPE_DEPTH + 1) done)
		else $error("speaker result missing after pipeline latency");

	// a speaker at or next to the source saturates the gain
	a_gain_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[PIPE_DEPTH] && one_q[PIPE_DEPTH]) |=> (gain == GAIN_MAX))
		else $error("gain not saturated for tiny distance");

	// zero samples per meter forces a zero delay
	a_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DSQ_END] && zs_q[DSQ_END]) |=> (dly_q[DLY_STAGE] == '0))
		else $error("delay not zero for zero samples per meter");

endmodule
`default_nettype wire

// ===== test/tb_wfs_speaker_gain_delay_unit.sv =====
`default_nettype none
module tb_wfs_speaker_gain_delay_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import wfs_pkg::*;

	typedef struct {
		logic [6:0]  idx;
		logic        act;
		logic [15:0] gain;
		logic [18:0] delay;
	} drive_vals_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [6:0]  speaker_index = '0;
	logic [15:0] speaker_x = '0;
	logic [15:0] speaker_y = '0;
	logic [16:0] speaker_facing = '0;
	logic        done;
	logic [6:0]  result_index;
	logic        active;
	logic [15:0] gain;
	logic [18:0] delay;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_SOURCE_X;
	logic [15:0] cfg_data = '0;

	// shadow copy of the source position and delay scale
	logic [15:0] src_x = '0;
	logic [15:0] src_y = '0;
	logic [15:0] spm = SPM_RESET;

	drive_vals_t pending_results[$];
	int          mismatches = 0;
	bit          no_gaps = 0;

	wfs_speaker_gain_delay_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.speaker_index(speaker_index), .speaker_x(speaker_x),
		.speaker_y(speaker_y), .speaker_facing(speaker_facing),
		.done(done), .result_index(result_index), .active(active),
		.gain(gain), .delay(delay), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Bearing from source to speaker in 1/128 degree: quarter-turn prerotation
	// into the right half plane, then vectoring CORDIC with floor shifts.
	function automatic longint bearing_of(longint dx, longint dy);
		longint x, y, z, nx, ny, xs, ys;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		x = dx * (longint'(1) << 20);
		y = dy * (longint'(1) << 20);
		if (x < 0) begin
			if (y >= 0) begin
				nx = y;
				ny = -x;
				z = longint'(QUARTER_TURN);
			end else begin
				nx = -y;
				ny = x;
				z = -longint'(QUARTER_TURN);
			end
			x = nx;
			y = ny;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				nx = x + ys;
				ny = y - xs;
				z += longint'(ATAN_TAB[i]);
			end else begin
				nx = x - ys;
				ny = y + xs;
				z -= longint'(ATAN_TAB[i]);
			end
			x = nx;
			y = ny;
		end
		return (z + 128) >>> 8;
	endfunction

	// Largest g with g^4 * r2 <= 2^64, bit by bit from the top.
	function automatic logic [15:0] rsqrt_gain(longint unsigned r2);
		longint unsigned lim, g, t, t2;
		g = 0;
		if (r2 <= 1)
			return GAIN_MAX;
		lim = 64'hFFFF_FFFF_FFFF_FFFF / r2;
		if (64'hFFFF_FFFF_FFFF_FFFF % r2 == r2 - 1)
			lim += 1;
		for (int b = 15; b >= 0; b--) begin
			t = g | (longint'(1) << b);
			t2 = t * t;
			if (t2 * t2 <= lim)
				g = t;
		end
		return g[15:0];
	endfunction

	// Largest d with (4096 d)^2 <= r2 * spm^2 + spm - 1; zero scale gives no delay.
	function automatic logic [18:0] sample_delay(longint unsigned r2, longint unsigned s);
		longint unsigned a, d, t, lhs;
		d = 0;
		if (s == 0)
			return '0;
		a = r2 * s;
		for (int b = 18; b >= 0; b--) begin
			t = d | (longint'(1) << b);
			lhs = (t * 4096) * (t * 4096);
			if (lhs / s <= a)
				d = t;
		end
		return d[18:0];
	endfunction

	function automatic drive_vals_t predict_speaker(logic [6:0] idx, logic [15:0] x,
			logic [15:0] y, logic [16:0] f);
		drive_vals_t r;
		longint dx, dy, fc, br;
		longint unsigned r2;
		dx = longint'($signed(x)) - longint'($signed(src_x));
		dy = longint'($signed(y)) - longint'($signed(src_y));
		fc = longint'($signed(f));
		br = bearing_of(dx, dy);
		r2 = longint'(dx * dx) + longint'(dy * dy);
		r.idx = idx;
		r.act = (br <= fc + longint'(HALF_SPAN)) && (br >= fc - longint'(HALF_SPAN));
		r.gain = rsqrt_gain(r2);
		r.delay = sample_delay(r2, longint'(spm));
		return r;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	// Predict at each input transfer and track every register write.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pending_results.push_back(predict_speaker(speaker_index, speaker_x,
				speaker_y, speaker_facing));
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SOURCE_X: src_x <= cfg_data;
				CFG_SOURCE_Y: src_y <= cfg_data;
				CFG_SPM:      spm <= cfg_data;
				default: ;
			endcase
		end
	end

	// Compare each strobed result against the oldest prediction.
	always @(posedge clk) begin
		drive_vals_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result for speaker %0d not expected",
					result_index));
			end else begin
				e = pending_results.pop_front();
				if (result_index !== e.idx)
					report_mismatch($sformatf("index %0d, want %0d", result_index, e.idx));
				if (active !== e.act)
					report_mismatch($sformatf("speaker %0d active %b, want %b",
						e.idx, active, e.act));
				if (gain !== e.gain)
					report_mismatch($sformatf("speaker %0d gain %0d, want %0d",
						e.idx, gain, e.gain));
				if (delay !== e.delay)
					report_mismatch($sformatf("speaker %0d delay %0d, want %0d",
						e.idx, delay, e.delay));
			end
		end
	end

	// Random gap: mostly none or short, now and then long.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (no_gaps || p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	// Present one speaker and hold until the transfer, then maybe idle.
	task automatic send_speaker(logic [6:0] idx, logic [15:0] x, logic [15:0] y,
			logic [16:0] f);
		int n;
		start <= 1'b1;
		speaker_index <= idx;
		speaker_x <= x;
		speaker_y <= y;
		speaker_facing <= f;
		do @(posedge clk); while (busy);
		n = pick_gap();
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop start and wait until every speaker in flight has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_scene(logic [15:0] sx, logic [15:0] sy, logic [15:0] s);
		drain();
		write_reg(CFG_SOURCE_X, sx);
		write_reg(CFG_SOURCE_Y, sy);
		write_reg(CFG_SPM, s);
		@(posedge clk);
	endtask

	// Corners of the fields and the named special cases, reset scene first.
	task automatic test_directed();
		send_speaker(7'd0, 16'd0, 16'd0, 17'd0);            // speaker on the source
		send_speaker(7'd127, 16'd1, 16'd0, 17'd0);          // r2 of one
		send_speaker(7'd1, 16'h8000, 16'h8000, 17'h1FFFF);  // far corner
		send_speaker(7'd2, 16'h7FFF, 16'h7FFF, 17'h0FFFF);
		send_speaker(7'd3, 16'hFF00, 16'd0, 17'd23040);     // negative x axis
		send_speaker(7'd4, 16'h8000, 16'd0, 17'h10000);
		send_speaker(7'd5, 16'd256, 16'd0, 17'd11520);      // edge of the span
		send_speaker(7'd6, 16'd256, 16'd0, 17'd11521);
		send_speaker(7'd7, 16'd256, 16'd0, -17'sd11520);
		send_speaker(7'd8, 16'd256, 16'd0, -17'sd11521);
		send_speaker(7'd9, 16'd0, 16'd256, 17'd11520);
		send_speaker(7'd10, 16'd0, 16'hFF00, -17'sd11520);
		send_speaker(7'd11, 16'hFFFF, 16'hFFFF, -17'sd46080);
		send_speaker(7'd12, 16'h1234, 16'hEDCB, 17'd46080);
		send_speaker(7'd13, 16'h5555, 16'hAAAA, 17'h0AAAA);
		send_speaker(7'd14, 16'hAAAA, 16'h5555, 17'h15555);
		set_scene(16'h8000, 16'h7FFF, 16'd0);               // zero delay scale
		send_speaker(7'd15, 16'h7FFF, 16'h8000, 17'd0);
		send_speaker(7'd16, 16'h8000, 16'h7FFF, 17'd0);
		send_speaker(7'd17, 16'd0, 16'd0, 17'd0);
	endtask

	// Random speakers around one scene: far, near and right at the span edge.
	task automatic test_scene(logic [15:0] sx, logic [15:0] sy, logic [15:0] s, int count);
		logic [15:0] x, y;
		logic [16:0] f;
		longint br;
		int kind;
		set_scene(sx, sy, s);
		no_gaps = ($urandom_range(3) == 0);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				no_gaps = !no_gaps;
			kind = $urandom_range(9);
			if (kind < 5) begin
				x = 16'($urandom);
				y = 16'($urandom);
			end else begin
				x = sx + 16'($signed($urandom_range(64)) - 32);
				y = sy + 16'($signed($urandom_range(64)) - 32);
			end
			br = bearing_of(longint'($signed(x)) - longint'($signed(sx)),
				longint'($signed(y)) - longint'($signed(sy)));
			case ($urandom_range(3))
				0: f = 17'($urandom);
				1: f = 17'(br + (($urandom_range(1)) ? 11520 : -11520)
					+ $signed($urandom_range(4)) - 2);
				default: f = 17'($signed($urandom_range(92160)) - 46080);
			endcase
			send_speaker(7'($urandom), x, y, f);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_scene(16'd0, 16'd0, 16'd32914, 260);
		test_scene(16'h7FFF, 16'h8000, 16'd1, 260);
		test_scene(16'h8000, 16'h7FFF, 16'hFFFF, 260);
		test_scene(16'($urandom), 16'($urandom), 16'($urandom), 260);
		test_scene(16'h0100, 16'hFE00, 16'd128, 260);
		test_scene(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)), 260);
		drain();
		repeat (130) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("wfs_speaker_gain_delay_unit regression: pass");
		else
			$display("wfs_speaker_gain_delay_unit regression: fail");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2000000;
		$display("wfs_speaker_gain_delay_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/wfs_pkg.sv
rtl/wfs_cordic_cell.sv
rtl/wfs_div_cell.sv
rtl/wfs_sqrt_cell.sv
rtl/wfs_speaker_gain_delay_unit.sv
test/tb_wfs_speaker_gain_delay_unit.sv
